// ===== hdl/tbsr_pkg.sv =====
`default_nettype none

package tbsr_pkg;

	localparam int POS_W  = 32;
	localparam int BYTE_W = 8;
	localparam int CNT_W  = 7;

	localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

	// sequencer states, one-hot
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_STORE = 7'b0000010,
		S_SWEEP = 7'b0000100,
		S_SCAN  = 7'b0001000,
		S_READ  = 7'b0010000,
		S_LOAD  = 7'b0100000,
		S_EMPTY = 7'b1000000
	} seq_state_t;

endpackage

`default_nettype wire

// ===== hdl/tcp_byte_stream_reassembler.sv =====
// TCP byte stream reassembler.
// Input channel (in_valid / in_stall): one item per handshake, a byte with its
// absolute 32-bit position, or a bare end mark. The block takes one item at a
// time; in_stall is high from the cycle after acceptance until the last result
// of that item has been loaded into the output register.
// Output channel (res_valid / res_stall): one registered stage. Each item gives
// one result per in-order byte released, or a single empty result
// (out_valid low) when nothing is released; last_of_run marks the final one.
// Config channel (cfg_valid / cfg_ready): writes window_capacity; always ready.
// Steps per item: accept, store, an optional end-mark sweep over the slots
// from the new end to the end of the window, run scan, then a read and one
// byte per cycle while res_stall is low (each load overlaps the read of the
// next byte). An item that releases nothing passes store, the optional sweep,
// scan and the empty state before its result is loaded; the next item can be
// taken once it is. The scan and the registered read of the byte memory set the pace.
// A stalled receiver simply holds the output register; the drain waits.
// Reset clears all held marks, counts, end state and sets window_capacity to
// 64; the byte memory itself is not cleared (held marks guard every read).
`default_nettype none

module tcp_byte_stream_reassembler #(
	parameter int WINDOW = 64
) (
	input  wire  logic                         clk,
	input  wire  logic                         arst_n,
	// config
	input  wire  logic                         cfg_valid,
	output logic                               cfg_ready,
	input  wire  logic [tbsr_pkg::CNT_W-1:0]   window_capacity,
	// input items
	input  wire  logic                         in_valid,
	output logic                               in_stall,
	input  wire  logic [tbsr_pkg::POS_W-1:0]   position,
	input  wire  logic [tbsr_pkg::BYTE_W-1:0]  byte_value,
	input  wire  logic                         carries_byte,
	input  wire  logic                         ends_stream,
	input  wire  logic [tbsr_pkg::CNT_W-1:0]   downstream_fill,
	// result items
	output logic                               res_valid,
	input  wire  logic                         res_stall,
	output logic                               out_valid,
	output logic [tbsr_pkg::BYTE_W-1:0]        out_byte,
	output logic                               last_of_run,
	output logic                               stream_finished,
	output logic [tbsr_pkg::CNT_W-1:0]         pending_count
);
	import tbsr_pkg::*;

	localparam int SLOT_W = $clog2(WINDOW);
	localparam logic [CNT_W-1:0]  WIN_C     = CNT_W'(WINDOW);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

	function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
			input logic [CNT_W-1:0] ofs);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(ofs);
		if (sum >= (CNT_W+1)'(WINDOW)) begin
			sum = sum - (CNT_W+1)'(WINDOW);
		end
		return sum[SLOT_W-1:0];
	endfunction

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + 1'b1;
	endfunction

	seq_state_t state_q;

	// architectural state
	logic [CNT_W-1:0]  cap_q;
	logic [POS_W-1:0]  next_q;
	logic [SLOT_W-1:0] head_q;
	logic [WINDOW-1:0] marks_q;
	logic [CNT_W-1:0]  held_q;
	logic              end_known_q;
	logic [POS_W-1:0]  end_pos_q;

	// captured item
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] byte_q;
	logic              carries_q;
	logic              ends_q;
	logic [CNT_W-1:0]  room_q;

	// sweep / scan / drain
	logic [CNT_W-1:0]  sw_k_q;
	logic [SLOT_W-1:0] sw_slot_q;
	logic [CNT_W-1:0]  scan_n_q;
	logic [SLOT_W-1:0] scan_slot_q;
	logic [CNT_W-1:0]  left_q;
	logic              step_fin_q;
	logic [CNT_W-1:0]  step_pend_q;

	// output register
	logic              res_valid_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              last_q;
	logic              fin_q;
	logic [CNT_W-1:0]  pend_q;

	// byte memory
	logic [BYTE_W-1:0] mem [WINDOW];
	logic [BYTE_W-1:0] rd_q;
	logic              rd_en;
	logic [SLOT_W-1:0] rd_addr;
	logic              wr_en;
	logic [SLOT_W-1:0] wr_addr;

	logic in_take;
	logic out_free;

	// accept-cycle terms
	logic [CNT_W-1:0] cap_eff;
	logic [CNT_W-1:0] room_in;
	logic [POS_W-1:0] end_dist;
	logic [POS_W-1:0] end_new;

	// store-cycle terms
	logic [POS_W-1:0]  off;
	logic [POS_W-1:0]  lim;
	logic              off_in_room;
	logic              store_ok;
	logic [SLOT_W-1:0] st_slot;
	logic              lim_small;

	// scan terms
	logic scan_go;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !res_valid_q || !res_stall;

	assign cap_eff = (cap_q < WIN_C) ? cap_q : WIN_C;
	assign room_in = (downstream_fill < cap_eff) ? cap_eff - downstream_fill : '0;

	// end position; a mark behind the reader collapses onto next_q
	assign end_dist = position + POS_W'(carries_byte) - next_q;
	assign end_new  = end_dist[POS_W-1] ? next_q : position + POS_W'(carries_byte);

	assign off         = pos_q - next_q;
	assign lim         = end_pos_q - next_q;
	assign off_in_room = (off[POS_W-1:CNT_W] == '0) && (off[CNT_W-1:0] < room_q);
	assign store_ok    = carries_q && off_in_room && !(end_known_q && off >= lim);
	assign st_slot     = slot_add(head_q, off[CNT_W-1:0]);
	assign lim_small   = (lim[POS_W-1:CNT_W] == '0) && (lim[CNT_W-1:0] < WIN_C);

	assign scan_go = (scan_n_q < room_q) && marks_q[scan_slot_q];

	assign wr_en   = (state_q == S_STORE) && store_ok && !marks_q[st_slot];
	assign wr_addr = st_slot;

	assign rd_en   = (state_q == S_READ) ||
		((state_q == S_LOAD) && out_free && (left_q != CNT_W'(1)));
	assign rd_addr = (state_q == S_READ) ? head_q : slot_inc(head_q);

	// store and drain never share a cycle, so no bypass is needed
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= byte_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// captured item and step bookkeeping (no reset needed)
	always_ff @(posedge clk) begin
		if (in_take) begin
			pos_q       <= position;
			byte_q      <= byte_value;
			carries_q   <= carries_byte;
			ends_q      <= ends_stream;
			room_q      <= room_in;
			scan_n_q    <= '0;
			scan_slot_q <= head_q;
		end
		if (state_q == S_STORE) begin
			sw_k_q    <= lim[CNT_W-1:0];
			sw_slot_q <= slot_add(head_q, lim[CNT_W-1:0]);
		end
		if (state_q == S_SWEEP) begin
			sw_k_q    <= sw_k_q + 1'b1;
			sw_slot_q <= slot_inc(sw_slot_q);
		end
		if (state_q == S_SCAN) begin
			if (scan_go) begin
				scan_n_q    <= scan_n_q + 1'b1;
				scan_slot_q <= slot_inc(scan_slot_q);
			end else begin
				left_q      <= scan_n_q;
				step_pend_q <= held_q - scan_n_q;
				step_fin_q  <= end_known_q && (next_q + POS_W'(scan_n_q) == end_pos_q);
			end
		end
		if ((state_q == S_LOAD) && out_free) begin
			left_q <= left_q - 1'b1;
		end
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= CAP_RESET;
			next_q      <= '0;
			head_q      <= '0;
			marks_q     <= '0;
			held_q      <= '0;
			end_known_q <= 1'b0;
			end_pos_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= window_capacity;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if (ends_stream) begin
							end_known_q <= 1'b1;
							end_pos_q   <= end_new;
						end
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					if (wr_en) begin
						marks_q[st_slot] <= 1'b1;
						held_q           <= held_q + 1'b1;
					end
					// bytes stored here lie below the end, so the sweep never hits them
					state_q <= (ends_q && lim_small) ? S_SWEEP : S_SCAN;
				end
				S_SWEEP: begin
					// drop held bytes at or beyond the new end
					if (marks_q[sw_slot_q]) begin
						marks_q[sw_slot_q] <= 1'b0;
						held_q             <= held_q - 1'b1;
					end
					if (sw_k_q == WIN_C - 1'b1) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// run length; held bytes never reach past the end position
					if (!scan_go) begin
						state_q <= (scan_n_q == '0) ? S_EMPTY : S_READ;
					end
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (out_free) begin
						marks_q[head_q] <= 1'b0;
						held_q          <= held_q - 1'b1;
						next_q          <= next_q + 1'b1;
						head_q          <= slot_inc(head_q);
						if (left_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_EMPTY: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (((state_q == S_LOAD) || (state_q == S_EMPTY)) && out_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == S_LOAD) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= rd_q;
				last_q      <= (left_q == CNT_W'(1));
				fin_q       <= step_fin_q;
				pend_q      <= step_pend_q;
			end else if (state_q == S_EMPTY) begin
				out_valid_q <= 1'b0;
				out_byte_q  <= '0;
				last_q      <= 1'b1;
				fin_q       <= step_fin_q;
				pend_q      <= step_pend_q;
			end
		end
	end

	assign res_valid       = res_valid_q;
	assign out_valid       = out_valid_q;
	assign out_byte        = out_byte_q;
	assign last_of_run     = last_q;
	assign stream_finished = fin_q;
	assign pending_count   = pend_q;

endmodule

`default_nettype wire

// ===== test/reassembly_check_pkg.sv =====
`default_nettype none

package reassembly_check_pkg;

	import tbsr_pkg::*;

	localparam int SLOTS = 64;

	typedef struct packed {
		logic                delivers;
		logic [BYTE_W-1:0]   data;
		logic                last;
		logic                finished;
		logic [CNT_W-1:0]    pending;
	} outcome_t;

	// Mirror of the reassembler state; predicts the results of every accepted item.
	class reassembly_tracker;
		logic [CNT_W-1:0]   capacity = CAP_RESET;
		logic [POS_W-1:0]   next_pos = '0;
		logic [BYTE_W-1:0]  data [SLOTS];
		bit                 held [SLOTS];
		int                 held_total = 0;
		bit                 end_known = 0;
		logic [POS_W-1:0]   end_pos = '0;
		int                 head = 0;
		int                 mismatches = 0;
		outcome_t           due_results[$];

		function void note_item(logic [POS_W-1:0] pos, logic [BYTE_W-1:0] val,
				logic carries, logic ends, logic [CNT_W-1:0] fill);
			int                 cap, room, s, k;
			logic [POS_W-1:0]   e, d, off;
			bit                 ok, finished;
			logic [BYTE_W-1:0]  run[$];
			outcome_t           o;
			cap  = (capacity < SLOTS) ? int'(capacity) : SLOTS;
			room = (int'(fill) < cap) ? cap - int'(fill) : 0;
			if (ends) begin
				e = carries ? pos + 1 : pos;
				d = e - next_pos;
				// end behind the reader snaps to the reader
				if (d[POS_W-1]) begin
					d = '0;
					e = next_pos;
				end
				end_known = 1;
				end_pos   = e;
				for (k = 0; k < SLOTS; k++) begin
					s = (head + k) % SLOTS;
					if (k >= d && held[s]) begin
						held[s] = 0;
						held_total--;
					end
				end
			end
			if (carries) begin
				off = pos - next_pos;
				ok  = off < room;
				if (end_known && off >= end_pos - next_pos)
					ok = 0;
				if (ok) begin
					s = (head + int'(off)) % SLOTS;
					if (!held[s]) begin
						data[s] = val;
						held[s] = 1;
						held_total++;
					end
				end
			end
			while (run.size() < room && held[head] && !(end_known && next_pos == end_pos)) begin
				run.push_back(data[head]);
				held[head] = 0;
				held_total--;
				head = (head + 1) % SLOTS;
				next_pos++;
			end
			finished = end_known && next_pos == end_pos;
			o.finished = finished;
			o.pending  = CNT_W'(held_total);
			if (run.size() == 0) begin
				o.delivers = 0;
				o.data     = '0;
				o.last     = 1;
				due_results.push_back(o);
			end else begin
				foreach (run[i]) begin
					o.delivers = 1;
					o.data     = run[i];
					o.last     = (i == run.size() - 1);
					due_results.push_back(o);
				end
			end
		endfunction

		task flag(string msg);
			$display("mismatch: %s", msg);
			mismatches++;
		endtask

		task check_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				flag($sformatf("%s got %0d, expected %0d", name, got, want));
		endtask

		task check_result(outcome_t got);
			outcome_t want;
			if (due_results.size() == 0) begin
				flag("result arrived with nothing outstanding");
				return;
			end
			want = due_results.pop_front();
			check_field("out_valid", got.delivers, want.delivers);
			check_field("out_byte", got.data, want.data);
			check_field("last_of_run", got.last, want.last);
			check_field("stream_finished", got.finished, want.finished);
			check_field("pending_count", got.pending, want.pending);
		endtask
	endclass

endpackage

`default_nettype wire

// ===== test/tcp_byte_stream_reassembler_test.sv =====
`default_nettype none

// Byte-at-a-time stream reassembler test: directed corner items, then random
// well-formed segments (shuffled bytes, duplicates, end marks) mixed with noise.
// Every accepted item is predicted by the tracker; every result is checked in order.
module tcp_byte_stream_reassembler_test;

	import tbsr_pkg::*;
	import reassembly_check_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int TIMEOUT_CYCLES = 1_000_000;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CNT_W-1:0]    window_capacity;
	logic                in_valid;
	logic                in_stall;
	logic [POS_W-1:0]    position;
	logic [BYTE_W-1:0]   byte_value;
	logic                carries_byte;
	logic                ends_stream;
	logic [CNT_W-1:0]    downstream_fill;
	logic                res_valid;
	logic                res_stall;
	logic                out_valid;
	logic [BYTE_W-1:0]   out_byte;
	logic                last_of_run;
	logic                stream_finished;
	logic [CNT_W-1:0]    pending_count;

	reassembly_tracker tracker = new;

	// idle odds in percent, per side; changed between phases
	int send_idle_pct  = 14;
	int recv_stall_pct = 81;
	int items_sent     = 0;

	tcp_byte_stream_reassembler #(
		.WINDOW(SLOTS)
	) i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.window_capacity (window_capacity),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.position        (position),
		.byte_value      (byte_value),
		.carries_byte    (carries_byte),
		.ends_stream     (ends_stream),
		.downstream_fill (downstream_fill),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.out_valid       (out_valid),
		.out_byte        (out_byte),
		.last_of_run     (last_of_run),
		.stream_finished (stream_finished),
		.pending_count   (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// receiver back-pressure: fresh coin every cycle
	always @(posedge clk) begin
		res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// result side: sample pre-edge values, so the handshake seen here is the
	// one the block sees at this same edge
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			tracker.check_result(outcome_t'{out_valid, out_byte, last_of_run,
				stream_finished, pending_count});
	end

	// Present one item, with random idle cycles ahead of it, and hold it until
	// the block takes it. The tracker predicts at the accepting edge.
	task automatic send_item(logic [POS_W-1:0] pos, logic [BYTE_W-1:0] val,
			logic carries, logic ends, logic [CNT_W-1:0] fill);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		position        <= pos;
		byte_value      <= val;
		carries_byte    <= carries;
		ends_stream     <= ends;
		downstream_fill <= fill;
		do
			@(posedge clk);
		while (in_stall);
		tracker.note_item(pos, val, carries, ends, fill);
		items_sent++;
	endtask

	// position relative to the reader's current spot (negative = already read)
	task automatic send_at(int rel, logic [BYTE_W-1:0] val, logic carries, logic ends,
			logic [CNT_W-1:0] fill);
		send_item(tracker.next_pos + POS_W'(rel), val, carries, ends, fill);
	endtask

	task automatic wait_drained();
		while (tracker.due_results.size() != 0)
			@(posedge clk);
	endtask

	// capacity only changes with the block idle: no item in flight, no result owed
	task automatic write_capacity(logic [CNT_W-1:0] cap);
		in_valid <= 1'b0;
		wait_drained();
		cfg_valid       <= 1'b1;
		window_capacity <= cap;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid        <= 1'b0;
		tracker.capacity = cap;
	endtask

	// mostly a nearly empty downstream buffer; sometimes enough fill to
	// squeeze the window and cut delivery short
	function automatic logic [CNT_W-1:0] pick_fill();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return CNT_W'($urandom_range(0, 3));
		else if (r < 97)
			return CNT_W'($urandom_range(0, 64));
		return CNT_W'($urandom_range(0, 127));
	endfunction

	// One well-formed segment starting at the reader: an end mark placed first
	// (bare, carried by the last byte, or far ahead and pulled in afterward),
	// then the bytes in shuffled order with occasional duplicates.
	task automatic send_segment(int len);
		int                 offs[$];
		int                 i, j, tmp, style;
		logic [POS_W-1:0]   base;
		base  = tracker.next_pos;
		style = $urandom_range(0, 2);
		for (i = 0; i < len; i++)
			offs.push_back(i);
		for (i = len - 1; i > 0; i--) begin
			j       = $urandom_range(0, i);
			tmp     = offs[i];
			offs[i] = offs[j];
			offs[j] = tmp;
		end
		case (style)
			0: send_item(base + len, 8'($urandom), 1'b0, 1'b1, pick_fill());
			1: send_item(base + len - 1, 8'($urandom), 1'b1, 1'b1, pick_fill());
			default: send_item(base + len + 40, 8'($urandom), 1'b0, 1'b1, pick_fill());
		endcase
		for (i = 0; i < len; i++) begin
			send_item(base + offs[i], 8'($urandom), 1'b1, 1'b0, pick_fill());
			// a retransmitted byte must not overwrite the held one
			if ($urandom_range(0, 99) < 15)
				send_item(base + offs[$urandom_range(0, i)], 8'($urandom), 1'b1, 1'b0,
					pick_fill());
		end
		if (style == 2)
			send_item(base + len, 8'($urandom), 1'b0, 1'b1, pick_fill());
	endtask

	// one capacity setting, then segments and noise until count items went in
	task automatic random_block(logic [CNT_W-1:0] cap, int count);
		int target;
		target = items_sent + count;
		write_capacity(cap);
		while (items_sent < target) begin
			if ($urandom_range(0, 99) < 75) begin
				if ($urandom_range(0, 99) < 6)
					send_segment($urandom_range(13, 64));
				else
					send_segment($urandom_range(1, 12));
			end else if ($urandom_range(0, 99) < 30) begin
				// anywhere in the 32-bit space
				send_item($urandom, 8'($urandom), 1'($urandom_range(0, 99) < 80),
					1'($urandom_range(0, 99) < 20), pick_fill());
			end else begin
				// near the reader: behind, inside and past the window
				send_at($urandom_range(0, 90) - 10, 8'($urandom),
					1'($urandom_range(0, 99) < 80), 1'($urandom_range(0, 99) < 20),
					pick_fill());
			end
		end
	endtask

	initial begin
		arst_n          <= 1'b0;
		cfg_valid       <= 1'b0;
		window_capacity <= '0;
		in_valid        <= 1'b0;
		position        <= '0;
		byte_value      <= '0;
		carries_byte    <= 1'b0;
		ends_stream     <= 1'b0;
		downstream_fill <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// ---- directed, reset capacity of 64 ----
		// first byte in order, all ones
		send_at(0, 8'hFF, 1'b1, 1'b0, 7'd0);
		// three bytes arriving backward: all released on the last one
		send_at(2, 8'h00, 1'b1, 1'b0, 7'd0);
		send_at(1, 8'h5A, 1'b1, 1'b0, 7'd0);
		send_at(0, 8'hA5, 1'b1, 1'b0, 7'd0);
		// duplicate keeps the first value
		send_at(1, 8'h11, 1'b1, 1'b0, 7'd0);
		send_at(1, 8'h22, 1'b1, 1'b0, 7'd0);
		send_at(0, 8'h33, 1'b1, 1'b0, 7'd0);
		// byte behind the reader is dropped
		send_at(-1, 8'h44, 1'b1, 1'b0, 7'd0);
		// downstream full: no room at all
		send_at(0, 8'h55, 1'b1, 1'b0, 7'd64);
		// window edge: last slot taken, one past it dropped
		send_at(63, 8'h77, 1'b1, 1'b0, 7'd0);
		send_at(64, 8'h88, 1'b1, 1'b0, 7'd0);
		// delivery cut to the room left, rest released by a later item
		send_at(1, 8'h01, 1'b1, 1'b0, 7'd0);
		send_at(2, 8'h02, 1'b1, 1'b0, 7'd0);
		send_at(3, 8'h03, 1'b1, 1'b0, 7'd0);
		send_at(0, 8'h00, 1'b1, 1'b0, 7'd62);
		send_at(-1, 8'hEE, 1'b1, 1'b0, 7'd0);
		// bare end mark behind the reader: ends right here, held bytes discarded
		send_at(-5, 8'h00, 1'b0, 1'b1, 7'd0);
		// end carried by a byte; a byte past it is dropped
		send_at(2, 8'hAB, 1'b1, 1'b1, 7'd0);
		send_at(3, 8'hCD, 1'b1, 1'b0, 7'd0);
		send_at(1, 8'hBC, 1'b1, 1'b0, 7'd0);
		send_at(0, 8'h9A, 1'b1, 1'b0, 7'd0);
		// a later end mark replaces an earlier one
		send_at(4, 8'h00, 1'b0, 1'b1, 7'd0);
		send_at(2, 8'h00, 1'b0, 1'b1, 7'd0);
		send_at(3, 8'h12, 1'b1, 1'b0, 7'd0);
		send_at(1, 8'h34, 1'b1, 1'b0, 7'd0);
		send_at(0, 8'h56, 1'b1, 1'b0, 7'd0);
		// all-ones fields; its end position wraps behind the reader
		send_item('1, 8'hFF, 1'b1, 1'b1, 7'd127);
		// capacity zero accepts nothing
		write_capacity(7'd0);
		send_at(20, 8'h00, 1'b0, 1'b1, 7'd0);
		send_at(0, 8'h42, 1'b1, 1'b0, 7'd0);

		// ---- random: sender mostly busy, receiver mostly stalled ----
		random_block(7'd127, 40);
		random_block(7'd1, 12);

		// ---- sender mostly idle, receiver mostly ready ----
		send_idle_pct  = 81;
		recv_stall_pct = 14;
		random_block(7'd64, 50);
		random_block(7'd20, 45);

		// ---- full speed both sides ----
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		random_block(7'd64, 50);
		random_block(CNT_W'($urandom_range(1, 127)), 50);

		in_valid <= 1'b0;
		wait_drained();
		// longest item: sweep plus scan plus drain
		repeat (4 * SLOTS) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.due_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
